// File: hw/rtl/aekd_pkg.sv
// Shared constants, token codes, control struct and decode functions
// for the ANSI escape key decoder. No dependencies.
package aekd_pkg;

    localparam int CSI_MAX_LEN = 15;
    localparam int CSI_LEN_W   = $clog2(CSI_MAX_LEN + 1);
    localparam int NUM_SAT     = 1000;
    localparam int NUM_W       = $clog2(NUM_SAT + 1);
    localparam int NUM_SUM_W   = $clog2(NUM_SAT * 10 + 10);

    localparam logic [15:0] TIMEOUT_RESET = 16'd50;

    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_Q     = 8'h51;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [7:0] TOK_ESC      = 8'd0;
    localparam logic [7:0] TOK_UNKNOWN  = 8'd1;
    localparam logic [7:0] TOK_UP       = 8'd2;
    localparam logic [7:0] TOK_HOME     = 8'd6;
    localparam logic [7:0] TOK_END      = 8'd7;
    localparam logic [7:0] TOK_SHIFT_UP = 8'd8;
    localparam logic [7:0] TOK_INS      = 8'd12;
    localparam logic [7:0] TOK_DEL      = 8'd13;
    localparam logic [7:0] TOK_PGUP     = 8'd14;
    localparam logic [7:0] TOK_PGDN     = 8'd15;
    localparam logic [7:0] TOK_F1       = 8'd16;
    localparam logic [7:0] TOK_F12      = 8'd27;

    localparam logic [1:0] REG_TIMEOUT = 2'd0;

    typedef struct packed {
        logic       clr;
        logic       push;
        logic [7:0] data;
    } csi_ctl_t;

    function automatic logic is_final(input logic [7:0] c);
        return (c >= CH_A && c <= CH_Z) || (c >= CH_LA && c <= CH_LZ) || c == CH_TILDE;
    endfunction

    function automatic logic is_arrow(input logic [7:0] c);
        return c >= CH_A && c <= CH_D;
    endfunction

    function automatic logic [7:0] arrow_off(input logic [7:0] c);
        return c - CH_A;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic [7:0] tilde_key(input logic [NUM_W-1:0] n);
        logic [7:0] k;
        unique case (n)
            NUM_W'(1):  k = TOK_HOME;
            NUM_W'(2):  k = TOK_INS;
            NUM_W'(3):  k = TOK_DEL;
            NUM_W'(4):  k = TOK_END;
            NUM_W'(5):  k = TOK_PGUP;
            NUM_W'(6):  k = TOK_PGDN;
            NUM_W'(11): k = TOK_F1;
            NUM_W'(12): k = TOK_F1 + 8'd1;
            NUM_W'(13): k = TOK_F1 + 8'd2;
            NUM_W'(14): k = TOK_F1 + 8'd3;
            NUM_W'(15): k = TOK_F1 + 8'd4;
            NUM_W'(17): k = TOK_F1 + 8'd5;
            NUM_W'(18): k = TOK_F1 + 8'd6;
            NUM_W'(19): k = TOK_F1 + 8'd7;
            NUM_W'(20): k = TOK_F1 + 8'd8;
            NUM_W'(21): k = TOK_F1 + 8'd9;
            NUM_W'(23): k = TOK_F1 + 8'd10;
            NUM_W'(24): k = TOK_F1 + 8'd11;
            default:    k = TOK_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] decode_ss3(input logic [7:0] c);
        logic [7:0] k;
        if (is_arrow(c))
        begin
            k = TOK_UP + arrow_off(c);
        end
        else
        begin
            unique case (c)
                CH_H:    k = TOK_HOME;
                CH_F:    k = TOK_END;
                CH_P:    k = TOK_F1;
                CH_Q:    k = TOK_F1 + 8'd1;
                CH_R:    k = TOK_F1 + 8'd2;
                CH_S:    k = TOK_F1 + 8'd3;
                default: k = TOK_UNKNOWN;
            endcase
        end
        return k;
    endfunction

endpackage

// File: hw/rtl/aekd_csi_acc.sv
// CSI sequence accumulator: tracks length, last byte, shift-arrow prefix
// and the leading number, and decodes the key. Depends on aekd_pkg.
module aekd_csi_acc (
    input  logic                           clk,
    input  logic                           rst_n,
    input  aekd_pkg::csi_ctl_t             ctl,
    output logic [aekd_pkg::CSI_LEN_W-1:0] len,
    output logic [7:0]                     key
);

    typedef enum logic [1:0] {
        PH_WS,
        PH_DIG,
        PH_DONE
    } phase_t;

    logic [aekd_pkg::CSI_LEN_W-1:0] len_reg, len_next;
    logic [7:0]                     last_reg, last_next;
    logic                           pre_ok_reg, pre_ok_next;
    logic                           neg_reg, neg_next;
    logic [aekd_pkg::NUM_W-1:0]     num_reg, num_next;
    phase_t                         phase_reg, phase_next;
    logic [aekd_pkg::NUM_SUM_W-1:0] num_sum;

    always_comb
    begin
        len_next    = len_reg;
        last_next   = last_reg;
        pre_ok_next = pre_ok_reg;
        neg_next    = neg_reg;
        num_next    = num_reg;
        phase_next  = phase_reg;
        num_sum     = {1'b0, num_reg, 3'b000} + {3'b000, num_reg, 1'b0}
                    + aekd_pkg::NUM_SUM_W'(ctl.data[3:0]);
        if (ctl.clr)
        begin
            len_next    = '0;
            pre_ok_next = 1'b0;
            neg_next    = 1'b0;
            num_next    = '0;
            phase_next  = PH_WS;
        end
        else if (ctl.push)
        begin
            len_next  = len_reg + aekd_pkg::CSI_LEN_W'(1);
            last_next = ctl.data;
            if (len_reg == aekd_pkg::CSI_LEN_W'(0))
            begin
                pre_ok_next = ctl.data == aekd_pkg::CH_ONE;
            end
            else if (len_reg == aekd_pkg::CSI_LEN_W'(1))
            begin
                pre_ok_next = pre_ok_reg && ctl.data == aekd_pkg::CH_SEMI;
            end
            else if (len_reg == aekd_pkg::CSI_LEN_W'(2))
            begin
                pre_ok_next = pre_ok_reg && ctl.data == aekd_pkg::CH_TWO;
            end
            unique case (phase_reg)
                PH_WS:
                begin
                    if (aekd_pkg::is_ws(ctl.data))
                    begin
                        phase_next = PH_WS;
                    end
                    else if (ctl.data == aekd_pkg::CH_PLUS || ctl.data == aekd_pkg::CH_MINUS)
                    begin
                        neg_next   = ctl.data == aekd_pkg::CH_MINUS;
                        phase_next = PH_DIG;
                    end
                    else if (aekd_pkg::is_digit(ctl.data))
                    begin
                        num_next   = aekd_pkg::NUM_W'(ctl.data[3:0]);
                        phase_next = PH_DIG;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_DIG:
                begin
                    if (aekd_pkg::is_digit(ctl.data))
                    begin
                        if (num_sum > aekd_pkg::NUM_SUM_W'(aekd_pkg::NUM_SAT))
                        begin
                            num_next = aekd_pkg::NUM_W'(aekd_pkg::NUM_SAT);
                        end
                        else
                        begin
                            num_next = num_sum[aekd_pkg::NUM_W-1:0];
                        end
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    always_comb
    begin
        if (len_next == '0)
        begin
            key = aekd_pkg::TOK_UNKNOWN;
        end
        else if (len_next == aekd_pkg::CSI_LEN_W'(1) && aekd_pkg::is_arrow(last_next))
        begin
            key = aekd_pkg::TOK_UP + aekd_pkg::arrow_off(last_next);
        end
        else if (len_next == aekd_pkg::CSI_LEN_W'(1) && last_next == aekd_pkg::CH_H)
        begin
            key = aekd_pkg::TOK_HOME;
        end
        else if (len_next == aekd_pkg::CSI_LEN_W'(1) && last_next == aekd_pkg::CH_F)
        begin
            key = aekd_pkg::TOK_END;
        end
        else if (len_next == aekd_pkg::CSI_LEN_W'(4) && pre_ok_next
                 && aekd_pkg::is_arrow(last_next))
        begin
            key = aekd_pkg::TOK_SHIFT_UP + aekd_pkg::arrow_off(last_next);
        end
        else if (last_next != aekd_pkg::CH_TILDE)
        begin
            key = aekd_pkg::TOK_UNKNOWN;
        end
        else if (neg_next && num_next != '0)
        begin
            key = aekd_pkg::TOK_UNKNOWN;
        end
        else
        begin
            key = aekd_pkg::tilde_key(num_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            last_reg   <= '0;
            pre_ok_reg <= 1'b0;
            neg_reg    <= 1'b0;
            num_reg    <= '0;
            phase_reg  <= PH_WS;
        end
        else
        begin
            len_reg    <= len_next;
            last_reg   <= last_next;
            pre_ok_reg <= pre_ok_next;
            neg_reg    <= neg_next;
            num_reg    <= num_next;
            phase_reg  <= phase_next;
        end
    end

    assign len = len_reg;

`ifndef SYNTH
    a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= aekd_pkg::CSI_LEN_W'(aekd_pkg::CSI_MAX_LEN))
        else $error("csi length beyond buffer");

    a_num_sat: assert property (@(posedge clk) disable iff (!rst_n)
        num_reg <= aekd_pkg::NUM_W'(aekd_pkg::NUM_SAT))
        else $error("number not saturated");

    a_clr: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clr |=> (len_reg == '0 && phase_reg == PH_WS && num_reg == '0))
        else $error("clear did not reset accumulator");
`endif

endmodule

// File: hw/rtl/ansi_escape_key_decoder.sv
// Top level of the ANSI escape key decoder: mode control, timeout counter,
// result register and APB register. Depends on aekd_pkg and aekd_csi_acc.
//
// Input channel (in_valid/in_ready): each transaction is either one time
// tick (is_tick = 1) or one received byte (rx_byte). Output channel
// (out_valid/out_ready): at most one result per input transaction, a plain
// byte (is_special = 0) or a key token (is_special = 1) in key_code.
// A result is registered and appears on the output in the cycle after
// the input transaction that causes it. Throughput: one input
// transaction per cycle; the result register frees each cycle its
// contents are taken, so in_ready stays high while out_ready is high or
// the register is empty. When the receiver stalls with a result pending,
// in_ready drops until the result is taken. Decoding is incremental, one
// byte per cycle, so a CSI key is decoded as its final byte is taken.
// Reset (rst_n low, asynchronous): idle mode, tick count zero, no result
// pending, escape_timeout_ticks back to 50 (APB byte address 0).
module ansi_escape_key_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        is_tick,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        is_special,
    output logic [7:0]  key_code,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_ESC,
        MODE_CSI,
        MODE_SS3
    } mode_t;

    mode_t                          mode_reg, mode_next;
    logic [15:0]                    cnt_reg, cnt_next, cnt_inc;
    logic [15:0]                    timeout_reg;
    logic                           out_valid_reg;
    logic                           is_special_reg;
    logic [7:0]                     key_code_reg;
    logic                           emit;
    logic                           emit_special;
    logic [7:0]                     emit_code;
    logic                           accept;
    aekd_pkg::csi_ctl_t             csi_ctl;
    logic [aekd_pkg::CSI_LEN_W-1:0] csi_len;
    logic [7:0]                     csi_key;

    aekd_csi_acc u_csi (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (csi_ctl),
        .len   (csi_len),
        .key   (csi_key)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign cnt_inc  = (cnt_reg == 16'hFFFF) ? cnt_reg : cnt_reg + 16'd1;

    always_comb
    begin
        mode_next    = mode_reg;
        cnt_next     = cnt_reg;
        emit         = 1'b0;
        emit_special = 1'b1;
        emit_code    = aekd_pkg::TOK_UNKNOWN;
        csi_ctl.clr  = 1'b0;
        csi_ctl.push = 1'b0;
        csi_ctl.data = rx_byte;
        if (accept)
        begin
            if (is_tick)
            begin
                if (mode_reg != MODE_IDLE)
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= timeout_reg)
                    begin
                        emit      = 1'b1;
                        mode_next = MODE_IDLE;
                        cnt_next  = '0;
                        unique case (mode_reg)
                            MODE_ESC: emit_code = aekd_pkg::TOK_ESC;
                            MODE_CSI: emit_code = csi_key;
                            default:  emit_code = aekd_pkg::TOK_UNKNOWN;
                        endcase
                    end
                end
            end
            else
            begin
                cnt_next = '0;
                unique case (mode_reg)
                    MODE_IDLE:
                    begin
                        if (rx_byte == aekd_pkg::CH_ESC)
                        begin
                            mode_next = MODE_ESC;
                        end
                        else
                        begin
                            emit         = 1'b1;
                            emit_special = 1'b0;
                            emit_code    = rx_byte;
                        end
                    end
                    MODE_ESC:
                    begin
                        if (rx_byte == aekd_pkg::CH_LBRK)
                        begin
                            mode_next   = MODE_CSI;
                            csi_ctl.clr = 1'b1;
                        end
                        else if (rx_byte == aekd_pkg::CH_O)
                        begin
                            mode_next = MODE_SS3;
                        end
                        else
                        begin
                            emit      = 1'b1;
                            mode_next = MODE_IDLE;
                        end
                    end
                    MODE_CSI:
                    begin
                        if (csi_len < aekd_pkg::CSI_LEN_W'(aekd_pkg::CSI_MAX_LEN))
                        begin
                            csi_ctl.push = 1'b1;
                            if (aekd_pkg::is_final(rx_byte))
                            begin
                                emit      = 1'b1;
                                emit_code = csi_key;
                                mode_next = MODE_IDLE;
                            end
                        end
                        else
                        begin
                            emit      = 1'b1;
                            emit_code = csi_key;
                            mode_next = MODE_IDLE;
                        end
                    end
                    default:
                    begin
                        emit      = 1'b1;
                        emit_code = aekd_pkg::decode_ss3(rx_byte);
                        mode_next = MODE_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            cnt_reg        <= '0;
            timeout_reg    <= aekd_pkg::TIMEOUT_RESET;
            out_valid_reg  <= 1'b0;
            is_special_reg <= 1'b0;
            key_code_reg   <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            if (psel && penable && pwrite && pready && paddr == aekd_pkg::REG_TIMEOUT)
            begin
                timeout_reg <= pwdata[15:0];
            end
            if (accept && emit)
            begin
                out_valid_reg  <= 1'b1;
                is_special_reg <= emit_special;
                key_code_reg   <= emit_code;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign is_special = is_special_reg;
    assign key_code   = key_code_reg;
    assign pready     = 1'b1;
    assign prdata     = (paddr == aekd_pkg::REG_TIMEOUT) ? {16'h0000, timeout_reg} : 32'h0;

`ifndef SYNTH
    a_plain_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_tick && mode_reg == MODE_IDLE && rx_byte != aekd_pkg::CH_ESC)
        |=> (out_valid && !is_special && key_code == $past(rx_byte)))
        else $error("plain byte not passed through");

    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_tick && mode_reg == MODE_IDLE)
        |=> (mode_reg == MODE_IDLE && cnt_reg == $past(cnt_reg)))
        else $error("tick in idle changed state");

    a_token_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_special) |-> (key_code <= aekd_pkg::TOK_F12))
        else $error("token out of range");

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_IDLE) |-> (cnt_reg == '0))
        else $error("tick count not cleared in idle");
`endif

endmodule

// File: dv/ansi_escape_key_decoder_tb.sv
// Testbench for ansi_escape_key_decoder: directed key sequences, timeouts,
// backpressure and random terminal traffic against a key predictor.
// Depends on aekd_pkg and the ansi_escape_key_decoder RTL.
`timescale 1ns / 100ps

module ansi_escape_key_decoder_tb;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [1:0] TIMEOUT_ADDR = 2'(4 * aekd_pkg::REG_TIMEOUT);
    localparam int TILDE_NUMS [18] = '{1, 2, 3, 4, 5, 6, 11, 12, 13, 14, 15,
                                       17, 18, 19, 20, 21, 23, 24};

    typedef enum logic [1:0] {PM_IDLE, PM_ESC, PM_CSI, PM_SS3} parse_mode_t;

    typedef struct packed {
        logic       is_special;
        logic [7:0] key_code;
    } key_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        is_tick;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic        is_special;
    logic [7:0]  key_code;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    key_result_t expected_keys [$];
    int          mismatches = 0;
    int          cycle_count = 0;
    int          decoded_items = 0;
    int          hold_left = 0;
    bit          src_gaps = 1'b1;
    bit          sink_gaps = 1'b1;

    logic [15:0] timeout_ticks;
    parse_mode_t parse_mode;
    logic [15:0] tick_count;
    int          seq_len;
    logic [7:0]  seq_buf [aekd_pkg::CSI_MAX_LEN];

    ansi_escape_key_decoder i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .is_tick    (is_tick),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .is_special (is_special),
        .key_code   (key_code),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // hold off for a counted stretch, else stall at random while sink_gaps is set
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (sink_gaps)
        begin
            out_ready <= ($urandom_range(99) >= 24);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(negedge clk)
    begin
        key_result_t exp_key;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_keys.size() == 0)
            begin
                $display("%0t: unexpected result is_special=%0b key_code=%h",
                         $time, is_special, key_code);
                mismatches++;
            end
            else
            begin
                exp_key = expected_keys.pop_front();
                if (is_special !== exp_key.is_special)
                begin
                    $display("%0t: is_special expected %0b actual %0b",
                             $time, exp_key.is_special, is_special);
                    mismatches++;
                end
                if (key_code !== exp_key.key_code)
                begin
                    $display("%0t: key_code expected %h actual %h",
                             $time, exp_key.key_code, key_code);
                    mismatches++;
                end
            end
        end
    end

    function automatic bit ends_csi(input logic [7:0] c);
        return (c >= aekd_pkg::CH_A && c <= aekd_pkg::CH_Z) ||
               (c >= aekd_pkg::CH_LA && c <= aekd_pkg::CH_LZ) || c == aekd_pkg::CH_TILDE;
    endfunction

    function automatic logic [7:0] tilde_token(input int n);
        case (n)
            1:                  return aekd_pkg::TOK_HOME;
            2:                  return aekd_pkg::TOK_INS;
            3:                  return aekd_pkg::TOK_DEL;
            4:                  return aekd_pkg::TOK_END;
            5:                  return aekd_pkg::TOK_PGUP;
            6:                  return aekd_pkg::TOK_PGDN;
            11, 12, 13, 14, 15: return aekd_pkg::TOK_F1 + 8'(n - 11);
            17, 18, 19, 20, 21: return aekd_pkg::TOK_F1 + 8'(n - 12);
            23, 24:             return aekd_pkg::TOK_F1 + 8'(n - 13);
            default:            return aekd_pkg::TOK_UNKNOWN;
        endcase
    endfunction

    function automatic logic [7:0] ss3_token(input logic [7:0] c);
        if (c >= aekd_pkg::CH_A && c <= aekd_pkg::CH_D)
            return aekd_pkg::TOK_UP + (c - aekd_pkg::CH_A);
        if (c == aekd_pkg::CH_H)
            return aekd_pkg::TOK_HOME;
        if (c == aekd_pkg::CH_F)
            return aekd_pkg::TOK_END;
        if (c >= aekd_pkg::CH_P && c <= aekd_pkg::CH_S)
            return aekd_pkg::TOK_F1 + (c - aekd_pkg::CH_P);
        return aekd_pkg::TOK_UNKNOWN;
    endfunction

    function automatic logic [7:0] csi_token();
        int         num_end;
        int         pos;
        int         num;
        bit         neg;
        logic [7:0] c0;
        logic [7:0] c3;
        neg = 1'b0;
        num = 0;
        if (seq_len == 0)
            return aekd_pkg::TOK_UNKNOWN;
        c0 = seq_buf[0];
        if (seq_len == 1)
        begin
            if (c0 >= aekd_pkg::CH_A && c0 <= aekd_pkg::CH_D)
                return aekd_pkg::TOK_UP + (c0 - aekd_pkg::CH_A);
            if (c0 == aekd_pkg::CH_H)
                return aekd_pkg::TOK_HOME;
            if (c0 == aekd_pkg::CH_F)
                return aekd_pkg::TOK_END;
        end
        if (seq_len == 4)
        begin
            c3 = seq_buf[3];
            if (c0 == aekd_pkg::CH_ONE && seq_buf[1] == aekd_pkg::CH_SEMI &&
                seq_buf[2] == aekd_pkg::CH_TWO &&
                c3 >= aekd_pkg::CH_A && c3 <= aekd_pkg::CH_D)
                return aekd_pkg::TOK_SHIFT_UP + (c3 - aekd_pkg::CH_A);
        end
        if (seq_buf[seq_len - 1] != aekd_pkg::CH_TILDE)
            return aekd_pkg::TOK_UNKNOWN;
        num_end = 0;
        while (num_end < seq_len - 1 && seq_buf[num_end] != aekd_pkg::CH_SEMI &&
               seq_buf[num_end] != 8'h00)
            num_end++;
        pos = 0;
        while (pos < num_end && (seq_buf[pos] == aekd_pkg::CH_SPACE ||
               (seq_buf[pos] >= aekd_pkg::CH_TAB && seq_buf[pos] <= aekd_pkg::CH_CR)))
            pos++;
        if (pos < num_end && (seq_buf[pos] == aekd_pkg::CH_PLUS ||
                              seq_buf[pos] == aekd_pkg::CH_MINUS))
        begin
            neg = (seq_buf[pos] == aekd_pkg::CH_MINUS);
            pos++;
        end
        while (pos < num_end && seq_buf[pos] >= aekd_pkg::CH_ZERO &&
               seq_buf[pos] <= aekd_pkg::CH_NINE)
        begin
            num = num * 10 + int'(seq_buf[pos] - aekd_pkg::CH_ZERO);
            if (num > 1000)
                num = 1000;
            pos++;
        end
        if (neg && num != 0)
            return aekd_pkg::TOK_UNKNOWN;
        return tilde_token(num);
    endfunction

    function automatic bit predict_key(input bit tick, input logic [7:0] c,
                                       output key_result_t res);
        res.is_special = 1'b1;
        res.key_code   = aekd_pkg::TOK_UNKNOWN;
        if (tick)
        begin
            if (parse_mode == PM_IDLE)
                return 1'b0;
            decoded_items++;
            if (tick_count != 16'hFFFF)
                tick_count++;
            if (tick_count < timeout_ticks)
                return 1'b0;
            if (parse_mode == PM_ESC)
                res.key_code = aekd_pkg::TOK_ESC;
            else if (parse_mode == PM_CSI)
                res.key_code = csi_token();
        end
        else
        begin
            decoded_items++;
            tick_count = 16'd0;
            case (parse_mode)
                PM_IDLE:
                begin
                    if (c == aekd_pkg::CH_ESC)
                    begin
                        parse_mode = PM_ESC;
                        return 1'b0;
                    end
                    res.is_special = 1'b0;
                    res.key_code   = c;
                    return 1'b1;
                end
                PM_ESC:
                begin
                    if (c == aekd_pkg::CH_LBRK)
                    begin
                        parse_mode = PM_CSI;
                        seq_len    = 0;
                        return 1'b0;
                    end
                    if (c == aekd_pkg::CH_O)
                    begin
                        parse_mode = PM_SS3;
                        return 1'b0;
                    end
                end
                PM_CSI:
                begin
                    if (seq_len < aekd_pkg::CSI_MAX_LEN)
                    begin
                        seq_buf[seq_len] = c;
                        seq_len++;
                        if (!ends_csi(c))
                            return 1'b0;
                    end
                    res.key_code = csi_token();
                end
                default:
                begin
                    res.key_code = ss3_token(c);
                end
            endcase
        end
        parse_mode = PM_IDLE;
        tick_count = 16'd0;
        seq_len    = 0;
        return 1'b1;
    endfunction

    task automatic send_item(input bit tick, input logic [7:0] b);
        bit          taken;
        logic [7:0]  sent;
        key_result_t res;
        sent = tick ? 8'($urandom) : b;
        while (src_gaps && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        is_tick  <= tick;
        rx_byte  <= sent;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
        if (predict_key(tick, sent, res))
            expected_keys.push_back(res);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(1'b0, b);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(1'b1, 8'h00);
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_csi(input string body);
        send_byte(aekd_pkg::CH_ESC);
        send_byte(aekd_pkg::CH_LBRK);
        send_string(body);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_keys.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_read_check();
        logic [31:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= TIMEOUT_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        rd = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== {16'h0000, timeout_ticks})
        begin
            $display("%0t: timeout register expected %h actual %h",
                     $time, {16'h0000, timeout_ticks}, rd);
            mismatches++;
        end
    endtask

    task automatic set_timeout(input logic [15:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TIMEOUT_ADDR;
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        timeout_ticks = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apb_read_check();
    endtask

    task automatic test_plain_bytes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_ticks(2);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(aekd_pkg::CH_LBRK);
        send_byte(aekd_pkg::CH_TILDE);
    endtask

    task automatic test_csi_keys();
        send_csi("A");
        send_csi("B");
        send_csi("C");
        send_csi("D");
        send_csi("H");
        send_csi("F");
        send_csi("1;2A");
        send_csi("1;2D");
        send_csi("1;2E");
        send_csi("2~");
        send_csi("24~");
        send_csi("16~");
        send_csi(" 3~");
        send_csi("\t4~");
        send_csi("+5~");
        send_csi("-1~");
        send_csi("-0~");
        send_csi("99999~");
        send_csi("6;5~");
        send_csi("1");
        send_byte(8'h00);
        send_byte(aekd_pkg::CH_TILDE);
    endtask

    task automatic test_csi_overflow();
        send_csi("000000000000000");
        send_byte(aekd_pkg::CH_ONE);
        send_byte(aekd_pkg::CH_Z);
        send_csi("00000000000002~");
    endtask

    task automatic test_ss3_keys();
        string keys;
        keys = "ABCDHFPQRSZ";
        for (int i = 0; i < keys.len(); i++)
        begin
            send_byte(aekd_pkg::CH_ESC);
            send_byte(aekd_pkg::CH_O);
            send_byte(keys[i]);
        end
    endtask

    task automatic test_escape_fallback();
        send_byte(aekd_pkg::CH_ESC);
        send_byte(aekd_pkg::CH_ESC);
        send_byte(aekd_pkg::CH_ESC);
        send_byte(8'h78);
        send_byte(aekd_pkg::CH_ESC);
        send_byte(8'hFF);
    endtask

    task automatic test_timeouts();
        set_timeout(16'd3);
        send_byte(aekd_pkg::CH_ESC);
        send_ticks(3);
        send_csi("5");
        send_ticks(1);
        send_byte(aekd_pkg::CH_ZERO);
        send_ticks(3);
        send_csi("");
        send_ticks(3);
        send_byte(aekd_pkg::CH_ESC);
        send_byte(aekd_pkg::CH_O);
        send_ticks(3);
        send_byte(aekd_pkg::CH_ESC);
        send_ticks(2);
        send_byte(aekd_pkg::CH_LBRK);
        send_ticks(2);
        send_byte(aekd_pkg::CH_A);
        set_timeout(16'd1);
        send_byte(aekd_pkg::CH_ESC);
        send_ticks(1);
        set_timeout(16'd0);
        send_byte(aekd_pkg::CH_ESC);
        send_ticks(1);
        send_csi("");
        send_ticks(1);
        set_timeout(16'hFFFF);
        send_byte(aekd_pkg::CH_ESC);
        send_ticks(20);
        send_byte(8'h78);
    endtask

    task automatic test_backpressure();
        wait_drained();
        src_gaps  = 1'b0;
        hold_left = 60;
        repeat (30) send_byte(8'($urandom_range(32, 126)));
        wait_drained();
        src_gaps  = 1'b1;
    endtask

    task automatic seq_byte(input logic [7:0] c);
        if ($urandom_range(99) < 4)
            send_ticks(1);
        send_byte(c);
    endtask

    task automatic csi_open();
        send_byte(aekd_pkg::CH_ESC);
        seq_byte(aekd_pkg::CH_LBRK);
    endtask

    function automatic logic [7:0] body_byte();
        int         r;
        logic [7:0] c;
        r = $urandom_range(99);
        if (r < 40)
            return aekd_pkg::CH_ZERO + 8'($urandom_range(0, 9));
        if (r < 50)
            return aekd_pkg::CH_SEMI;
        if (r < 55)
            return aekd_pkg::CH_SPACE;
        if (r < 60)
            return aekd_pkg::CH_TAB + 8'($urandom_range(0, 4));
        if (r < 65)
            return aekd_pkg::CH_PLUS;
        if (r < 70)
            return aekd_pkg::CH_MINUS;
        if (r < 75)
            return 8'h00;
        do
            c = 8'($urandom);
        while (ends_csi(c));
        return c;
    endfunction

    function automatic logic [7:0] random_letter();
        if ($urandom_range(1))
            return aekd_pkg::CH_A + 8'($urandom_range(0, 25));
        return aekd_pkg::CH_LA + 8'($urandom_range(0, 25));
    endfunction

    task automatic random_sequence();
        int         kind;
        int         num;
        int         count;
        logic [7:0] c;
        string      s;
        kind = $urandom_range(99);
        if (kind < 15)
        begin
            send_byte(8'($urandom));
        end
        else if (kind < 30)
        begin
            s = "ABCDHF";
            csi_open();
            seq_byte(($urandom_range(99) < 70) ? s[$urandom_range(0, 5)] : random_letter());
        end
        else if (kind < 40)
        begin
            s = "1;2";
            s = {s, string'(aekd_pkg::CH_A + 8'($urandom_range(0, 4)))};
            if ($urandom_range(99) < 20)
                s[$urandom_range(0, 2)] = body_byte();
            csi_open();
            for (int i = 0; i < 4; i++)
                seq_byte(s[i]);
        end
        else if (kind < 60)
        begin
            csi_open();
            if ($urandom_range(99) < 15)
                seq_byte(($urandom_range(1)) ? aekd_pkg::CH_SPACE :
                         aekd_pkg::CH_TAB + 8'($urandom_range(0, 4)));
            if ($urandom_range(99) < 15)
                seq_byte(($urandom_range(1)) ? aekd_pkg::CH_PLUS : aekd_pkg::CH_MINUS);
            count = $urandom_range(99);
            if (count < 60)
                num = TILDE_NUMS[$urandom_range(0, 17)];
            else if (count < 85)
                num = $urandom_range(0, 30);
            else
                num = $urandom_range(0, 99999);
            s = $sformatf("%0d", num);
            if ($urandom_range(99) < 10)
                s = {"0", s};
            for (int i = 0; i < s.len(); i++)
                seq_byte(s[i]);
            if ($urandom_range(99) < 20)
            begin
                seq_byte(aekd_pkg::CH_SEMI);
                seq_byte(aekd_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            end
            seq_byte(aekd_pkg::CH_TILDE);
        end
        else if (kind < 70)
        begin
            s = "ABCDHFPQRSZ";
            send_byte(aekd_pkg::CH_ESC);
            seq_byte(aekd_pkg::CH_O);
            seq_byte(($urandom_range(1)) ? s[$urandom_range(0, 10)] : 8'($urandom));
        end
        else if (kind < 77)
        begin
            send_byte(aekd_pkg::CH_ESC);
            seq_byte(8'($urandom));
        end
        else if (kind < 87)
        begin
            csi_open();
            count = $urandom_range(0, 17);
            repeat (count) seq_byte(body_byte());
            if ($urandom_range(1))
                seq_byte(($urandom_range(1)) ? aekd_pkg::CH_TILDE : random_letter());
            else
                send_ticks(int'(timeout_ticks));
        end
        else
        begin
            c = ($urandom_range(1)) ? aekd_pkg::CH_LBRK : aekd_pkg::CH_O;
            if ($urandom_range(99) < 75)
                send_byte(aekd_pkg::CH_ESC);
            if ($urandom_range(99) < 50)
                send_byte(c);
            send_ticks($urandom_range(1, int'(timeout_ticks) + 1));
        end
    endtask

    task automatic random_phase(input logic [15:0] timeout, input int count);
        int stop_at;
        set_timeout(timeout);
        stop_at = decoded_items + count;
        while (decoded_items < stop_at)
            random_sequence();
        send_byte(aekd_pkg::CH_LZ);
    endtask

    task automatic test_random_traffic();
        random_phase(16'd4, 240);
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        random_phase(16'd1, 220);
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        random_phase(16'($urandom_range(2, 7)), 240);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        is_tick   = 1'b0;
        rx_byte   = 8'h00;
        out_ready = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = 2'd0;
        pwdata    = 32'h0;

        timeout_ticks = aekd_pkg::TIMEOUT_RESET;
        parse_mode    = PM_IDLE;
        tick_count    = 16'd0;
        seq_len       = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_read_check();
        test_plain_bytes();
        test_csi_keys();
        test_csi_overflow();
        test_ss3_keys();
        test_escape_fallback();
        test_timeouts();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_keys.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/aekd_pkg.sv
hw/rtl/aekd_csi_acc.sv
hw/rtl/ansi_escape_key_decoder.sv
dv/ansi_escape_key_decoder_tb.sv
